@@ rtl/i2a_pkg.sv @@
// Shared types, codes and character constants of the integer to ASCII formatter.
package i2a_pkg;

  localparam int VALUE_W = 32;
  localparam int NDIGITS = 10;
  localparam int BCD_W   = 4 * NDIGITS;
  localparam int CNT_W   = $clog2(VALUE_W);

  localparam logic [2:0] ACT_UDEC = 3'd0;
  localparam logic [2:0] ACT_SDEC = 3'd1;
  localparam logic [2:0] ACT_HEX  = 3'd2;
  localparam logic [2:0] ACT_FIXU = 3'd3;
  localparam logic [2:0] ACT_FIXS = 3'd4;

  localparam logic [3:0] MAX_DEC = 4'd9;
  localparam logic [3:0] MAX_HEX = 4'd8;
  localparam logic [3:0] MIN_HEX = 4'd1;

  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_POINT = 7'h2E;

  typedef struct packed {
    logic       hex;
    logic       fixed;
    logic       neg;
    logic [3:0] dec;
    logic [3:0] hexd;
  } emit_cfg_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'h0: c = 7'h30;
      4'h1: c = 7'h31;
      4'h2: c = 7'h32;
      4'h3: c = 7'h33;
      4'h4: c = 7'h34;
      4'h5: c = 7'h35;
      4'h6: c = 7'h36;
      4'h7: c = 7'h37;
      4'h8: c = 7'h38;
      4'h9: c = 7'h39;
      4'hA: c = 7'h41;
      4'hB: c = 7'h42;
      4'hC: c = 7'h43;
      4'hD: c = 7'h44;
      4'hE: c = 7'h45;
      default: c = 7'h46;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/i2a_bcd.sv @@
// Bit-serial binary to BCD converter using the shift and add-three method.
module i2a_bcd (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [i2a_pkg::VALUE_W-1:0]    bin,
  output logic                           done,
  output logic [i2a_pkg::BCD_W-1:0]      bcd
);

  logic [i2a_pkg::VALUE_W-1:0] sr;
  logic [i2a_pkg::CNT_W-1:0]   cnt;
  logic                        busy;
  logic [i2a_pkg::BCD_W-1:0]   adj;

  always_comb begin
    for (int i = 0; i < i2a_pkg::NDIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr  <= bin;
      bcd <= '0;
      cnt <= i2a_pkg::CNT_W'(i2a_pkg::VALUE_W - 1);
    end else if (busy) begin
      bcd <= {adj[i2a_pkg::BCD_W-2:0], sr[i2a_pkg::VALUE_W-1]};
      sr  <= {sr[i2a_pkg::VALUE_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/i2a_emit.sv @@
// Character sequencer walking the digits one per cycle unless stalled.
module i2a_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  i2a_pkg::emit_cfg_t         cfg_in,
  input  logic [i2a_pkg::BCD_W-1:0]  digits,
  output logic                       done,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [6:0] character, [7] zero
  output logic                       m_tlast
);

  i2a_pkg::emit_cfg_t         cfg;
  logic [i2a_pkg::BCD_W-1:0]  sr;
  logic [3:0]                 pos;
  logic                       busy;
  logic                       sign_pend;
  logic                       point_done;
  logic                       started;

  logic [3:0] d;
  logic [3:0] int_low;
  logic       slot_free;
  logic       go;
  logic       point_now;
  logic       skip;

  assign d         = sr[i2a_pkg::BCD_W-1 -: 4];
  assign int_low   = cfg.fixed ? cfg.dec : 4'd0;
  assign slot_free = !m_tvalid || m_tready;
  assign go        = busy && slot_free;
  assign point_now = cfg.fixed && !point_done && (pos < cfg.dec);
  assign skip      = cfg.hex ? (pos >= cfg.hexd)
                             : (!started && d == 4'd0 && pos > int_low);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (start) begin
        busy <= 1'b1;
      end else if (go) begin
        if (sign_pend || point_now) begin
          m_tvalid <= 1'b1;
        end else if (!skip) begin
          m_tvalid <= 1'b1;
          if (pos == 4'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cfg        <= cfg_in;
      sr         <= digits;
      pos        <= 4'(i2a_pkg::NDIGITS - 1);
      sign_pend  <= cfg_in.neg;
      point_done <= 1'b0;
      started    <= 1'b0;
    end else if (go) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
        m_tdata   <= {1'b0, i2a_pkg::CH_MINUS};
        m_tlast   <= 1'b0;
      end else if (point_now) begin
        point_done <= 1'b1;
        m_tdata    <= {1'b0, i2a_pkg::CH_POINT};
        m_tlast    <= 1'b0;
      end else begin
        sr  <= {sr[i2a_pkg::BCD_W-5:0], 4'd0};
        pos <= pos - 1'b1;
        if (!skip) begin
          started <= 1'b1;
          m_tdata <= {1'b0, i2a_pkg::digit_char(d)};
          m_tlast <= (pos == 4'd0);
        end
      end
    end
  end

endmodule

@@ rtl/integer_to_ascii_formatter_core.sv @@
// Top level of the integer to ASCII formatter: input decode, sequencing and output.
// Hex beats go straight to the sequencer; decimal and fixed-point beats pass through the
// binary to BCD converter first, and each suppressed leading zero takes a sequencer step.
// A new beat is taken only once the sequencer has issued the last character of the previous
// text, and the sequencer waits while a full output register is stalled. Reset clears the
// state machine and the busy, done and output valid flags.
module integer_to_ascii_formatter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [35:32] hex_digits, [39:36] decimals
  input  logic [2:0]  s_tuser,   // [2:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
  output logic        m_tlast
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  i2a_pkg::emit_cfg_t             cfg;
  i2a_pkg::emit_cfg_t             cfg_now;
  logic [i2a_pkg::VALUE_W-1:0]    value;
  logic [i2a_pkg::VALUE_W-1:0]    mag;
  logic [3:0]                     hexd_in;
  logic [3:0]                     dec_in;
  logic [2:0]                     action;
  logic                           signed_mode;
  logic                           accept;
  logic                           bcd_done;
  logic [i2a_pkg::BCD_W-1:0]      bcd;
  logic                           emit_start;
  logic                           emit_done;
  logic [i2a_pkg::BCD_W-1:0]      emit_digits;

  assign value   = s_tdata[31:0];
  assign hexd_in = s_tdata[35:32];
  assign dec_in  = s_tdata[39:36];
  assign action  = s_tuser;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    signed_mode   = (action == i2a_pkg::ACT_SDEC) || (action == i2a_pkg::ACT_FIXS);
    cfg_now.hex   = (action == i2a_pkg::ACT_HEX);
    cfg_now.fixed = ((action == i2a_pkg::ACT_FIXU) || (action == i2a_pkg::ACT_FIXS))
                    && (dec_in != 4'd0);
    cfg_now.neg   = !cfg_now.hex && signed_mode && value[i2a_pkg::VALUE_W-1];
    cfg_now.dec   = (dec_in > i2a_pkg::MAX_DEC) ? i2a_pkg::MAX_DEC : dec_in;
    if (hexd_in < i2a_pkg::MIN_HEX) begin
      cfg_now.hexd = i2a_pkg::MIN_HEX;
    end else if (hexd_in > i2a_pkg::MAX_HEX) begin
      cfg_now.hexd = i2a_pkg::MAX_HEX;
    end else begin
      cfg_now.hexd = hexd_in;
    end
    mag = cfg_now.neg ? ('0 - value) : value;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = cfg_now.hex ? S_EMIT : S_CONV;
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cfg <= cfg_now;
    end
  end

  assign emit_start  = (accept && cfg_now.hex) || (state == S_CONV && bcd_done);
  assign emit_digits = (state == S_CONV) ? bcd
                                         : {{(i2a_pkg::BCD_W - i2a_pkg::VALUE_W){1'b0}}, value};

  i2a_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (accept && !cfg_now.hex),
    .bin   (mag),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  i2a_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .start    (emit_start),
    .cfg_in   ((state == S_IDLE) ? cfg_now : cfg),
    .digits   (emit_digits),
    .done     (emit_done),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/i2a_checker.sv @@
// Port-level checker for the integer to ASCII formatter, bound to the top level.
module i2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Output beat changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input taken again right after a beat was accepted.");

  a_ascii_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[7])
    else $error("Output character is not seven-bit ASCII.");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("Input ready while a text is still being sent.");

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
